// File: hdl/phs_pkg.sv
// Shared constants, register codes and inter-module types for the pc sample histogram.
package phs_pkg;

   localparam int BINS       = 4096;
   localparam int BIN_W      = $clog2(BINS);
   localparam int PC_WIDTH   = 32;
   localparam int TICK_W     = 16;
   localparam int RBIN_W     = 12;
   localparam int COUNT_W    = 16;
   localparam int SCALE_W    = 17;
   localparam int BYTES_W    = 14;
   localparam int FRAC_BITS  = 16;
   localparam int PROD_W     = PC_WIDTH + SCALE_W;
   localparam int IDX_W      = PROD_W - FRAC_BITS;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1 << FRAC_BITS);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PC_OFFSET    = 2'd0,
      REG_PC_SCALE     = 2'd1,
      REG_BUFFER_BYTES = 2'd2,
      REG_ENABLE       = 2'd3
   } csr_reg_type;

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_READ   = 1'b1
   } cmd_type;

   typedef struct packed {
      logic [PC_WIDTH-1:0] pc_offset;
      logic [SCALE_W-1:0]  pc_scale;
      logic [BYTES_W-1:0]  buffer_bytes;
      logic                enable;
   } cfg_type;

   // One resolved access to the counter store.
   typedef struct packed {
      logic               counted;     // add ticks and write back
      logic               load;        // read beat with a bin inside the store
      logic [BIN_W-1:0]   addr;
      logic [RBIN_W-1:0]  bin_number;
      logic [TICK_W-1:0]  ticks;
   } op_type;

endpackage

// File: hdl/phs_ifs.sv
// Valid/ready channel interfaces for sample/read requests and bin responses.
interface phs_req_if;
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic [phs_pkg::PC_WIDTH-1:0]  pc;
   logic [phs_pkg::TICK_W-1:0]    ticks;
   logic [phs_pkg::RBIN_W-1:0]    read_bin;

   modport source (output valid, output cmd, output pc, output ticks, output read_bin,
                   input ready);
   modport sink (input valid, input cmd, input pc, input ticks, input read_bin,
                 output ready);
endinterface

interface phs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          counted;
   logic [phs_pkg::RBIN_W-1:0]    bin_number;
   logic [phs_pkg::COUNT_W-1:0]   bin_count;

   modport source (output valid, output counted, output bin_number, output bin_count,
                   input ready);
   modport sink (input valid, input counted, input bin_number, input bin_count,
                 output ready);
endinterface

// File: hdl/phs_index_pipe.sv
// Request pipeline: input register, offset/scale multiply, range checks to a store access.
module phs_index_pipe (
   input  logic             clock,
   input  logic             reset,
   phs_req_if.sink          req,
   input  phs_pkg::cfg_type cfg,
   input  logic             busy,
   output logic             op_valid,
   output phs_pkg::op_type  op,
   input  logic             op_ready
);

   localparam int BW = phs_pkg::IDX_W - 1;

   logic                           free1, free2, free3, fire;
   logic                           s1_v_ff, s1_v_in;
   logic                           s1_cmd_ff;
   logic [phs_pkg::PC_WIDTH-1:0]   s1_pc_ff;
   logic [phs_pkg::TICK_W-1:0]     s1_ticks_ff;
   logic [phs_pkg::RBIN_W-1:0]     s1_rbin_ff;

   logic                           s2_v_ff, s2_v_in;
   logic                           s2_cmd_ff;
   logic                           s2_ok_ff, s2_ok_in;
   logic [phs_pkg::PROD_W-1:0]     s2_prod_ff, s2_prod_in;
   logic [phs_pkg::TICK_W-1:0]     s2_ticks_ff;
   logic [phs_pkg::RBIN_W-1:0]     s2_rbin_ff;
   logic [phs_pkg::PC_WIDTH-1:0]   delta;

   logic                           s3_v_ff, s3_v_in;
   phs_pkg::op_type                s3_op_ff, s3_op_in;
   logic [phs_pkg::IDX_W-1:0]      idx_even;
   logic [BW-1:0]                  bin_wide;
   logic                           hit;

   // each stage moves when the one after it is empty or moving
   assign free3     = !s3_v_ff || op_ready;
   assign free2     = !s2_v_ff || free3;
   assign free1     = !s1_v_ff || free2;
   assign req.ready = free1 && !busy;
   assign fire      = req.valid && req.ready;

   assign s1_v_in = fire || (s1_v_ff && !free2);
   assign s2_v_in = (s1_v_ff && free2) || (s2_v_ff && !free3);
   assign s3_v_in = (s2_v_ff && free3) || (s3_v_ff && !op_ready);

   // stage 2: pc relative to offset, times 1.16 scale
   always_comb begin
      delta      = s1_pc_ff - cfg.pc_offset;
      s2_prod_in = phs_pkg::PROD_W'(delta) * phs_pkg::PROD_W'(cfg.pc_scale);
      s2_ok_in   = cfg.enable && (cfg.pc_scale != '0) && (s1_ticks_ff != '0) &&
                   (s1_pc_ff >= cfg.pc_offset);
   end

   // stage 3: byte index, size and store bounds
   always_comb begin
      idx_even    = s2_prod_ff[phs_pkg::PROD_W-1:phs_pkg::FRAC_BITS];
      idx_even[0] = 1'b0;
      bin_wide    = idx_even[phs_pkg::IDX_W-1:1];
      hit         = s2_ok_ff && (idx_even < phs_pkg::IDX_W'(cfg.buffer_bytes)) &&
                    (bin_wide < BW'(phs_pkg::BINS));
      s3_op_in    = '0;
      s3_op_in.ticks = s2_ticks_ff;
      if (s2_cmd_ff == phs_pkg::CMD_READ) begin
         s3_op_in.load       = 32'(s2_rbin_ff) < 32'(phs_pkg::BINS);
         s3_op_in.addr       = phs_pkg::BIN_W'(s2_rbin_ff);
         s3_op_in.bin_number = s2_rbin_ff;
      end else if (hit) begin
         s3_op_in.counted    = 1'b1;
         s3_op_in.addr       = phs_pkg::BIN_W'(bin_wide);
         s3_op_in.bin_number = phs_pkg::RBIN_W'(bin_wide);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
         s3_v_ff <= s3_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         s1_cmd_ff   <= req.cmd;
         s1_pc_ff    <= req.pc;
         s1_ticks_ff <= req.ticks;
         s1_rbin_ff  <= req.read_bin;
      end
      if (free2) begin
         s2_cmd_ff   <= s1_cmd_ff;
         s2_ok_ff    <= s2_ok_in;
         s2_prod_ff  <= s2_prod_in;
         s2_ticks_ff <= s1_ticks_ff;
         s2_rbin_ff  <= s1_rbin_ff;
      end
      if (free3) begin
         s3_op_ff    <= s3_op_in;
      end
   end

   assign op_valid = s3_v_ff;
   assign op       = s3_op_ff;

endmodule

// File: hdl/phs_bin_store.sv
// Counter memory with clearing sweep, read-modify-write stage, forwarding and output register.
module phs_bin_store (
   input  logic             clock,
   input  logic             reset,
   input  logic             op_valid,
   input  phs_pkg::op_type  op,
   output logic             op_ready,
   phs_rsp_if.source        rsp,
   output logic             busy
);

   logic [phs_pkg::COUNT_W-1:0]  mem [phs_pkg::BINS];

   logic                         clr_busy_ff, clr_busy_in;
   logic [phs_pkg::BIN_W-1:0]    clr_addr_ff, clr_addr_in;

   logic                         op_fire, free_o, mv4;
   logic                         s4_v_ff, s4_v_in;
   phs_pkg::op_type              s4_op_ff;
   logic [phs_pkg::COUNT_W-1:0]  rd_data_ff;

   logic                         fwd_v_ff, fwd_v_in;
   logic [phs_pkg::BIN_W-1:0]    fwd_addr_ff;
   logic [phs_pkg::COUNT_W-1:0]  fwd_data_ff;

   logic [phs_pkg::COUNT_W-1:0]  old_count, sum, result;
   logic                         wr_en;
   logic [phs_pkg::BIN_W-1:0]    wr_addr;
   logic [phs_pkg::COUNT_W-1:0]  wr_data;

   logic                         out_v_ff, out_v_in;
   logic                         out_counted_ff;
   logic [phs_pkg::RBIN_W-1:0]   out_bin_ff;
   logic [phs_pkg::COUNT_W-1:0]  out_count_ff;

   assign busy        = clr_busy_ff;
   assign clr_busy_in = clr_busy_ff && (clr_addr_ff != '1);
   assign clr_addr_in = clr_addr_ff + phs_pkg::BIN_W'(1);

   assign free_o   = !out_v_ff || rsp.ready;
   assign mv4      = s4_v_ff && free_o;
   assign op_ready = !s4_v_ff || mv4;
   assign op_fire  = op_valid && op_ready;
   assign s4_v_in  = op_fire || (s4_v_ff && !mv4);
   assign out_v_in = mv4 || (out_v_ff && !rsp.ready);

   // the write of the previous beat lands at the edge this beat was read
   always_comb begin
      old_count = (fwd_v_ff && (fwd_addr_ff == s4_op_ff.addr)) ? fwd_data_ff : rd_data_ff;
      sum       = old_count + s4_op_ff.ticks;
      if (s4_op_ff.counted) begin
         result = sum;
      end else if (s4_op_ff.load) begin
         result = old_count;
      end else begin
         result = '0;
      end
      fwd_v_in = s4_op_ff.counted;
      wr_en    = clr_busy_ff || (mv4 && s4_op_ff.counted);
      wr_addr  = clr_busy_ff ? clr_addr_ff : s4_op_ff.addr;
      wr_data  = clr_busy_ff ? '0 : sum;
   end

   always_ff @(posedge clock) begin
      if (op_fire) begin
         rd_data_ff <= mem[op.addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         s4_v_ff     <= 1'b0;
         fwd_v_ff    <= 1'b0;
         out_v_ff    <= 1'b0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_in;
         end
         s4_v_ff  <= s4_v_in;
         out_v_ff <= out_v_in;
         if (mv4) begin
            fwd_v_ff <= fwd_v_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (op_fire) begin
         s4_op_ff <= op;
      end
      if (mv4) begin
         fwd_addr_ff    <= s4_op_ff.addr;
         fwd_data_ff    <= sum;
         out_counted_ff <= s4_op_ff.counted;
         out_bin_ff     <= s4_op_ff.bin_number;
         out_count_ff   <= result;
      end
   end

   assign rsp.valid      = out_v_ff;
   assign rsp.counted    = out_counted_ff;
   assign rsp.bin_number = out_bin_ff;
   assign rsp.bin_count  = out_count_ff;

   a_no_op_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !op_fire)
      else $error("store access accepted during clearing sweep");

   a_write_lands: assert property (@(posedge clock) disable iff (reset)
      (mv4 && s4_op_ff.counted && !clr_busy_ff) |=>
         mem[$past(s4_op_ff.addr)] == $past(sum))
      else $error("updated bin not written back");

   a_clear_full_sweep: assert property (@(posedge clock) disable iff (reset)
      $fell(clr_busy_ff) |-> $past(clr_addr_ff) == '1)
      else $error("clearing sweep ended early");

   a_counted_matches_stage: assert property (@(posedge clock) disable iff (reset)
      mv4 |=> out_v_ff && (out_counted_ff == $past(s4_op_ff.counted)))
      else $error("response does not follow the update stage");

endmodule

// File: hdl/pc_sample_histogram_top.sv
// Program counter sampling histogram: control registers, request pipeline and counter store.
//
// Accepts one beat per cycle, sample or read, unless the response side stalls or the clearing
// sweep runs, and returns one response beat per request in order. A request passes the input
// register, 32x17 offset/scale multiply, index and range checks, then one read-modify-write
// of the 4096 x 16 counter memory (registered read, forwarded when consecutive samples hit
// the same bin) before it reaches the response register. After reset a clearing sweep
// writes zero to every bin, one per cycle; requests are not accepted until it ends, CSR
// writes are. CSR writes (pc_offset, pc_scale, buffer_bytes, enable) must be made only while
// no request is in flight; the block does not enforce it. A pc_scale over 1.0 (65536) is ignored.
module pc_sample_histogram_top (
   input  logic                              clock,
   input  logic                              reset,
   phs_req_if.sink                           req_ch,
   phs_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [phs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [phs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   phs_pkg::cfg_type  cfg_ff;
   phs_pkg::op_type   op;
   logic              op_valid, op_ready, busy;
   logic [phs_pkg::SCALE_W-1:0] scale_wr;

   assign scale_wr = csr_wdata[phs_pkg::SCALE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (phs_pkg::csr_reg_type'(csr_index))
            phs_pkg::REG_PC_OFFSET: begin
               cfg_ff.pc_offset <= csr_wdata[phs_pkg::PC_WIDTH-1:0];
            end
            phs_pkg::REG_PC_SCALE: begin
               if (scale_wr <= phs_pkg::SCALE_ONE) begin
                  cfg_ff.pc_scale <= scale_wr;
               end
            end
            phs_pkg::REG_BUFFER_BYTES: begin
               cfg_ff.buffer_bytes <= csr_wdata[phs_pkg::BYTES_W-1:0];
            end
            phs_pkg::REG_ENABLE: begin
               cfg_ff.enable <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   phs_index_pipe u_index (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .cfg      (cfg_ff),
      .busy     (busy),
      .op_valid (op_valid),
      .op       (op),
      .op_ready (op_ready)
   );

   phs_bin_store u_store (
      .clock    (clock),
      .reset    (reset),
      .op_valid (op_valid),
      .op       (op),
      .op_ready (op_ready),
      .rsp      (rsp_ch),
      .busy     (busy)
   );

endmodule
